/* rtl/hex_grid_outside_fill_labeler_top_defines.svh */
// Assertion macros for the hex grid outside fill labeler.
`ifndef HEX_GRID_OUTSIDE_FILL_LABELER_TOP_DEFINES_SVH
`define HEX_GRID_OUTSIDE_FILL_LABELER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HGOFL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hgofl assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define HGOFL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hgofl assertion failed");

`endif

/* rtl/hgofl_pkg.sv */
// Package: types and constants of the hex grid outside fill labeler.
`timescale 1ns / 1ps
`default_nettype none
package hgofl_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_PARITY = 2'd2;
  localparam logic [1:0] REG_BASE   = 2'd3;

  typedef struct packed {
    logic        bnd;
    logic        outside;
    logic [12:0] val;
  } cell_t;

  // neighbour step along one axis
  typedef enum logic [1:0] {
    D_MINUS = 2'd0,
    D_ZERO  = 2'd1,
    D_PLUS  = 2'd2
  } delta_t;

  localparam int NUM_NB = 6;

  localparam delta_t PAT_A_DR [NUM_NB] = '{D_ZERO, D_PLUS, D_MINUS, D_PLUS, D_ZERO, D_PLUS};
  localparam delta_t PAT_A_DC [NUM_NB] = '{D_MINUS, D_MINUS, D_ZERO, D_ZERO, D_PLUS, D_PLUS};
  localparam delta_t PAT_B_DR [NUM_NB] = '{D_MINUS, D_ZERO, D_MINUS, D_PLUS, D_MINUS, D_ZERO};
  localparam delta_t PAT_B_DC [NUM_NB] = '{D_MINUS, D_MINUS, D_ZERO, D_ZERO, D_PLUS, D_PLUS};

  localparam logic [12:0] COUNT_MAX = 13'h1FFF;

endpackage
`default_nettype wire

/* rtl/hgofl_in_if.sv */
// Interfaces: item, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface hgofl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [5:0]  row;
  logic [5:0]  col;
  logic        is_boundary;
  logic [11:0] boundary_index;
  modport source(output valid, op, row, col, is_boundary, boundary_index, input ready);
  modport sink(input valid, op, row, col, is_boundary, boundary_index, output ready);
endinterface

interface hgofl_out_if;
  logic        valid;
  logic        ready;
  logic        is_outside;
  logic        is_boundary_cell;
  logic [12:0] label;
  logic [12:0] interior_count;
  modport source(output valid, is_outside, is_boundary_cell, label, interior_count,
                 input ready);
  modport sink(input valid, is_outside, is_boundary_cell, label, interior_count,
               output ready);
endinterface

interface hgofl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/hex_grid_outside_fill_labeler_top.sv */
// Top level: hex grid outside fill labeler with cell memory and fill sequencer.
//
// Usage:
//  in_ch  : items (op, row, col, is_boundary, boundary_index). A transfer on
//           in_ch gives exactly one transfer on out_ch.
//  out_ch : results, held in an output register until taken.
//  cfg_ch : register writes (0 rows, 1 cols, 2 column parity, 3 label base),
//           always ready; write only while the block is idle.
// Sequence: a write's result shows the cycle after it is taken. A read goes
//  through ST_RD for the registered memory read. A run has a clear pass
//  (ST_CLR_RD, ST_CLR_WR per cell, seeding cell 0,0 as outside), flood sweeps
//  (ST_FL_C, ST_FL_CHK, ST_NB_ISS/ST_NB_CHK per neighbour) until a sweep
//  changes nothing, a numbering pass (ST_NUM_RD, ST_NUM_WR) and ST_DONE.
// Stall: an item is taken only in ST_IDLE and when the output register is free
//  or being emptied in the same cycle; a stalled receiver holds in_ch off.
// Reset: control state and registers cleared; rows/cols back to 64.
//  Cell memory is not cleared, every cell must be written before a run.
`timescale 1ns / 1ps
`default_nettype none
`include "hex_grid_outside_fill_labeler_top_defines.svh"
module hex_grid_outside_fill_labeler_top #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire         clk,
  input  wire         rst,
  hgofl_in_if.sink    in_ch,
  hgofl_out_if.source out_ch,
  hgofl_cfg_if.sink   cfg_ch
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_RD     = 11'b00000000010,
    ST_CLR_RD = 11'b00000000100,
    ST_CLR_WR = 11'b00000001000,
    ST_FL_C   = 11'b00000010000,
    ST_FL_CHK = 11'b00000100000,
    ST_NB_ISS = 11'b00001000000,
    ST_NB_CHK = 11'b00010000000,
    ST_NUM_RD = 11'b00100000000,
    ST_NUM_WR = 11'b01000000000,
    ST_DONE   = 11'b10000000000
  } state_t;

  state_t state;

  // configuration
  logic [6:0]  grid_rows, grid_cols;
  logic        column_parity;
  logic [11:0] label_base;

  // sweep position
  logic [6:0]  r, c;
  logic [2:0]  k;
  logic        pass_changed;
  logic [12:0] next_label;
  logic [12:0] count;
  logic        rd_inside;

  // cell memory
  hgofl_pkg::cell_t mem [DEPTH];
  hgofl_pkg::cell_t mem_q;
  logic [AW-1:0]    rd_addr, wr_addr;
  hgofl_pkg::cell_t wr_data;
  logic             we;

  logic acc, in_inside, out_free, out_set;
  logic [AW-1:0] in_addr, cur_addr, nb_addr;
  logic [6:0] nr, nc, nb_r, nb_c;
  logic nb_ok, last_cell, last_col, empty_q;
  hgofl_pkg::delta_t dr, dc;

  function automatic logic [AW-1:0] cell_addr(input logic [6:0] rr, input logic [6:0] cc);
    cell_addr = AW'(AW'(rr) * AW'(MAX_COLS) + AW'(cc));
  endfunction

  // clamp the grid size to the store
  always_comb begin
    if (grid_rows == 7'd0) nr = 7'd1;
    else if (int'(grid_rows) > MAX_ROWS) nr = 7'(MAX_ROWS);
    else nr = grid_rows;
    if (grid_cols == 7'd0) nc = 7'd1;
    else if (int'(grid_cols) > MAX_COLS) nc = 7'(MAX_COLS);
    else nc = grid_cols;
  end

  assign out_free  = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) && out_free;
  assign acc       = in_ch.valid && in_ch.ready;
  assign in_inside = (int'(in_ch.row) < MAX_ROWS) && (int'(in_ch.col) < MAX_COLS);
  assign in_addr   = cell_addr({1'b0, in_ch.row}, {1'b0, in_ch.col});
  assign cur_addr  = cell_addr(r, c);
  assign last_col  = (7'(c + 7'd1) == nc);
  assign last_cell = last_col && (7'(r + 7'd1) == nr);
  assign empty_q   = !mem_q.bnd && !mem_q.outside;

  // a result is loaded: write or idle op at once, read and run when finished
  assign out_set = (state == ST_RD) || (state == ST_DONE) ||
                   (acc && (in_ch.op != hgofl_pkg::OP_READ) &&
                    (in_ch.op != hgofl_pkg::OP_RUN));

  // neighbour k of the current cell; pattern picked by column parity
  always_comb begin
    if (c[0] == column_parity) begin
      dr = hgofl_pkg::PAT_B_DR[k];
      dc = hgofl_pkg::PAT_B_DC[k];
    end else begin
      dr = hgofl_pkg::PAT_A_DR[k];
      dc = hgofl_pkg::PAT_A_DC[k];
    end
    nb_ok = 1'b1;
    case (dr)
      hgofl_pkg::D_MINUS: begin
        nb_r = 7'(r - 7'd1);
        if (r == 7'd0) nb_ok = 1'b0;
      end
      hgofl_pkg::D_PLUS: begin
        nb_r = 7'(r + 7'd1);
        if (7'(r + 7'd1) == nr) nb_ok = 1'b0;
      end
      default: nb_r = r;
    endcase
    case (dc)
      hgofl_pkg::D_MINUS: begin
        nb_c = 7'(c - 7'd1);
        if (c == 7'd0) nb_ok = 1'b0;
      end
      hgofl_pkg::D_PLUS: begin
        nb_c = 7'(c + 7'd1);
        if (last_col) nb_ok = 1'b0;
      end
      default: nb_c = c;
    endcase
  end

  assign nb_addr = cell_addr(nb_r, nb_c);

  // memory port control
  always_comb begin
    we      = 1'b0;
    wr_addr = cur_addr;
    wr_data = mem_q;
    case (state)
      ST_IDLE: begin
        rd_addr = in_addr;
        wr_addr = in_addr;
        wr_data = in_ch.is_boundary ? {1'b1, 1'b0, 1'b0, in_ch.boundary_index} : '0;
        we      = acc && (in_ch.op == hgofl_pkg::OP_WRITE) && in_inside;
      end
      ST_CLR_WR: begin
        rd_addr = cur_addr;
        wr_data = {mem_q.bnd, (r == 7'd0) && (c == 7'd0), mem_q.val};
        we      = 1'b1;
      end
      ST_NB_ISS: rd_addr = nb_addr;
      ST_NB_CHK: begin
        rd_addr = nb_addr;
        wr_addr = nb_addr;
        wr_data = {mem_q.bnd, 1'b1, mem_q.val};
        we      = empty_q;
      end
      ST_NUM_WR: begin
        rd_addr = cur_addr;
        wr_data = {2'b00, next_label};
        we      = empty_q;
      end
      default: rd_addr = cur_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    mem_q <= mem[rd_addr];
  end

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows     <= 7'd64;
      grid_cols     <= 7'd64;
      column_parity <= 1'b0;
      label_base    <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        hgofl_pkg::REG_ROWS:   grid_rows     <= cfg_ch.data[6:0];
        hgofl_pkg::REG_COLS:   grid_cols     <= cfg_ch.data[6:0];
        hgofl_pkg::REG_PARITY: column_parity <= cfg_ch.data[0];
        hgofl_pkg::REG_BASE:   label_base    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_ch.valid <= 1'b0;
      r            <= '0;
      c            <= '0;
      k            <= '0;
      pass_changed <= 1'b0;
      next_label   <= '0;
      count        <= '0;
      rd_inside    <= 1'b0;
    end else begin
      if (out_set) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (acc) begin
            out_ch.is_outside       <= 1'b0;
            out_ch.is_boundary_cell <= 1'b0;
            out_ch.label            <= '0;
            out_ch.interior_count   <= '0;
            case (in_ch.op)
              hgofl_pkg::OP_READ: begin
                rd_inside <= in_inside;
                state     <= ST_RD;
              end
              hgofl_pkg::OP_RUN: begin
                r     <= '0;
                c     <= '0;
                state <= ST_CLR_RD;
              end
              default: ;
            endcase
          end
        end
        ST_RD: begin
          if (rd_inside) begin
            out_ch.is_outside <= mem_q.outside;
            if (!mem_q.outside) begin
              out_ch.is_boundary_cell <= mem_q.bnd;
              out_ch.label            <= mem_q.val;
            end
          end
          state <= ST_IDLE;
        end
        ST_CLR_RD: state <= ST_CLR_WR;
        ST_CLR_WR: begin
          if (last_cell) begin
            r            <= '0;
            c            <= '0;
            pass_changed <= 1'b0;
            state        <= ST_FL_C;
          end else begin
            c     <= last_col ? 7'd0 : 7'(c + 7'd1);
            r     <= last_col ? 7'(r + 7'd1) : r;
            state <= ST_CLR_RD;
          end
        end
        ST_FL_C: state <= ST_FL_CHK;
        ST_FL_CHK, ST_NB_ISS, ST_NB_CHK: begin
          logic step_done, chg;
          step_done = 1'b0;
          chg       = pass_changed;
          if (state == ST_FL_CHK) begin
            if (mem_q.outside) begin
              k     <= '0;
              state <= ST_NB_ISS;
            end else begin
              step_done = 1'b1;
            end
          end else if ((state == ST_NB_ISS) && nb_ok) begin
            state <= ST_NB_CHK;
          end else begin
            if ((state == ST_NB_CHK) && empty_q) chg = 1'b1;
            if (k == 3'(hgofl_pkg::NUM_NB - 1)) begin
              step_done = 1'b1;
            end else begin
              k     <= 3'(k + 3'd1);
              state <= ST_NB_ISS;
            end
          end
          // a new sweep starts with the change flag clear
          if (step_done && last_cell) pass_changed <= 1'b0;
          else pass_changed <= chg;
          if (step_done) begin
            if (last_cell) begin
              r <= '0;
              c <= '0;
              if (chg) begin
                state <= ST_FL_C;
              end else begin
                next_label <= {1'b0, label_base};
                count      <= '0;
                state      <= ST_NUM_RD;
              end
            end else begin
              c     <= last_col ? 7'd0 : 7'(c + 7'd1);
              r     <= last_col ? 7'(r + 7'd1) : r;
              state <= ST_FL_C;
            end
          end
        end
        ST_NUM_RD: state <= ST_NUM_WR;
        ST_NUM_WR: begin
          if (empty_q) begin
            next_label <= 13'(next_label + 13'd1);
            if (count != hgofl_pkg::COUNT_MAX) count <= 13'(count + 13'd1);
          end
          if (last_cell) begin
            state <= ST_DONE;
          end else begin
            c     <= last_col ? 7'd0 : 7'(c + 7'd1);
            r     <= last_col ? 7'(r + 7'd1) : r;
            state <= ST_NUM_RD;
          end
        end
        ST_DONE: begin
          out_ch.interior_count <= count;
          state                 <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // every accepted item either shows a result or keeps the sequencer busy
  `HGOFL_ASSERT_NEXT(a_acc_progress, acc, out_ch.valid || (state != ST_IDLE))
  // a run keeps the input closed in the cycle after it is taken
  `HGOFL_ASSERT_NEXT(a_run_busy, acc && (in_ch.op == hgofl_pkg::OP_RUN), !in_ch.ready)
  // a result appears only after an accepted item or sequencer work
  `HGOFL_ASSERT_IMPL(a_no_phantom, $rose(out_ch.valid), $past(acc || (state != ST_IDLE)))

endmodule
`default_nettype wire
